FILE: src/mbhr_pkg.sv
package mbhr_pkg;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_VALUE       = 2'd1,
    ST_ADDRESS     = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_e;

  // Supported function codes
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_WRITE_SINGLE  = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI   = 8'd16;

  // Depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  function_code;
    logic [7:0]  byte_count;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] data_word;
    logic [15:0] written_index;
    logic [6:0]  written_count;
    logic        last_result;
  } rsp_t;

  // What the back end does after an optional memory write
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_RESULT = 2'd1,
    ACT_READ   = 2'd2
  } act_e;

  typedef struct packed {
    logic        wr_en;
    logic [15:0] idx;      // write index, or first read index
    logic [15:0] wr_data;
    act_e        act;
    logic [6:0]  rd_cnt;
    rsp_t        res;      // result, or template for a read burst
  } op_t;

endpackage

FILE: src/mbhr_ram.sv
module mbhr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/mbhr_queue.sv
module mbhr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mbhr_pkg::op_t  op_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mbhr_pkg::op_t  op_o
);
  import mbhr_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  op_t           buf_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = buf_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= op_i;
    end
  end

endmodule

FILE: src/mbhr_front.sv
module mbhr_front #(
  parameter int unsigned REG_COUNT      = 64,
  parameter int unsigned MAX_READ_REGS  = 64,
  parameter int unsigned MAX_WRITE_REGS = 123
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  mbhr_pkg::req_t req_i,
  input  logic [15:0]    holding_start_i,
  output logic           op_push_o,
  output mbhr_pkg::op_t  op_o
);
  import mbhr_pkg::*;

  logic [7:0]  pos_q, pos_d;
  logic [7:0]  hdr_q [6];
  logic [7:0]  hdr_e [6];
  logic [15:0] wp_q, wp_d, wb_q, wb_d;
  logic [1:0]  ferr_q, ferr_d;
  logic [7:0]  phb_q, phb_d;
  logic [7:0]  fc, b;
  logic [15:0] addr, cnt, req_addr, idx;
  logic        win_lo, win_hi, win1_hi;
  op_t         op;

  assign b = req_i.pdu_byte;

  // Decode the frame and build the command for the back end
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hdr_e[i] = (pos_q == 8'(i)) ? b : hdr_q[i];
    end
    fc       = hdr_e[0];
    req_addr = {hdr_e[1], hdr_e[2]};
    addr     = req_addr + 16'd1;
    cnt      = {hdr_e[3], hdr_e[4]};
    idx      = addr - holding_start_i;
    win_lo   = (addr >= holding_start_i);
    win_hi   = ({2'b0, addr} + {2'b0, cnt}) <= ({2'b0, holding_start_i} + 18'(REG_COUNT));
    win1_hi  = ({2'b0, addr} + 18'd1) <= ({2'b0, holding_start_i} + 18'(REG_COUNT));

    pos_d  = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
    wp_d   = wp_q;
    wb_d   = wb_q;
    ferr_d = ferr_q;
    phb_d  = phb_q;
    op     = '0;
    op.act = ACT_NONE;

    // Write-multiple header check and data pairs
    if (fc == FC_WRITE_MULTI) begin
      if (pos_q == 8'd5) begin
        if (cnt < 16'd1 || cnt > 16'(MAX_WRITE_REGS) || {9'b0, b} != {cnt, 1'b0}) begin
          ferr_d = ST_VALUE;
        end else if (!(win_lo && win_hi)) begin
          ferr_d = ST_ADDRESS;
        end else begin
          wb_d = idx;
          wp_d = idx;
        end
      end else if (pos_q > 8'd5 && ferr_q == 2'd0) begin
        if (!pos_q[0]) begin
          phb_d = b;
        end else if ((wp_q - wb_q) < cnt && {1'b0, wp_q} < 17'(REG_COUNT)) begin
          op.wr_en   = 1'b1;
          op.idx     = wp_q;
          op.wr_data = {phb_q, b};
          wp_d       = wp_q + 16'd1;
        end
      end
    end

    // Final byte: issue the response
    if (req_i.last_byte) begin
      op.act                  = ACT_RESULT;
      op.res.function_code    = fc;
      op.res.last_result      = 1'b1;
      unique case (fc)
        FC_READ_HOLDING: begin
          if (pos_q != 8'd4 || cnt < 16'd1 || cnt > 16'(MAX_READ_REGS)) begin
            op.res.status = ST_VALUE;
          end else if (!(win_lo && win_hi)) begin
            op.res.status = ST_ADDRESS;
          end else begin
            op.act                 = ACT_READ;
            op.idx                 = idx;
            op.rd_cnt              = cnt[6:0];
            op.res.status          = ST_OK;
            op.res.byte_count      = {cnt[6:0], 1'b0};
            op.res.start_address   = req_addr;
            op.res.quantity        = cnt;
            op.res.last_result     = 1'b0;
          end
        end
        FC_WRITE_SINGLE: begin
          if (pos_q != 8'd4) begin
            op.res.status = ST_VALUE;
          end else if (!(win_lo && win1_hi)) begin
            op.res.status = ST_ADDRESS;
          end else begin
            op.wr_en               = 1'b1;
            op.idx                 = idx;
            op.wr_data             = cnt;
            op.res.status          = ST_OK;
            op.res.start_address   = req_addr;
            op.res.quantity        = cnt;
            op.res.written_index   = idx;
            op.res.written_count   = 7'd1;
          end
        end
        FC_WRITE_MULTI: begin
          if (pos_q < 8'd5) begin
            op.res.status = ST_VALUE;
          end else if (ferr_d != 2'd0) begin
            op.res.status = ferr_d;
          end else begin
            op.res.status          = ST_OK;
            op.res.start_address   = req_addr;
            op.res.quantity        = cnt;
            op.res.written_index   = wb_d;
            op.res.written_count   = 7'(wp_d - wb_d);
          end
        end
        default: begin
          op.res.status = ST_UNSUPPORTED;
        end
      endcase
      // Drop frame state
      pos_d  = '0;
      wp_d   = '0;
      wb_d   = '0;
      ferr_d = '0;
      phb_d  = '0;
    end
  end

  assign op_o      = op;
  assign op_push_o = accept_i && (op.wr_en || op.act != ACT_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      wp_q   <= '0;
      wb_q   <= '0;
      ferr_q <= '0;
      phb_q  <= '0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      wp_q   <= wp_d;
      wb_q   <= wb_d;
      ferr_q <= ferr_d;
      phb_q  <= phb_d;
    end
  end

  // Capture header bytes
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int i = 0; i < 6; i++) begin
        hdr_q[i] <= hdr_e[i];
      end
    end
  end

endmodule

FILE: src/mbhr_back.sv
module mbhr_back #(
  parameter int unsigned REG_COUNT = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  mbhr_pkg::op_t  op_i,
  output logic           op_pop_o,
  output logic           busy_clear_o,
  output logic           empty_o,
  input  logic           pop_i,
  output mbhr_pkg::rsp_t rsp_o
);
  import mbhr_pkg::*;

  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_RDREQ  = 4'b0100,
    S_RDWAIT = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d, rd_idx_q, rd_idx_d;
  logic [6:0]    rem_q, rem_d;
  rsp_t          tpl_q, tpl_d, out_q, out_d;
  logic          ov_q, ov_d, slot_free;
  logic          we, re;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata, rdata;

  assign slot_free = !ov_q || pop_i;

  // Sequence clearing, commands and read bursts
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    rd_idx_d = rd_idx_q;
    rem_d    = rem_q;
    tpl_d    = tpl_q;
    out_d    = out_q;
    ov_d     = ov_q && !pop_i;
    op_pop_o = 1'b0;
    we       = 1'b0;
    waddr    = clr_q;
    wdata    = '0;
    re       = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(REG_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (op_valid_i && slot_free) begin
          op_pop_o = 1'b1;
          we       = op_i.wr_en;
          waddr    = op_i.idx[AW-1:0];
          wdata    = op_i.wr_data;
          case (op_i.act)
            ACT_RESULT: begin
              out_d = op_i.res;
              ov_d  = 1'b1;
            end
            ACT_READ: begin
              tpl_d    = op_i.res;
              rd_idx_d = op_i.idx[AW-1:0];
              rem_d    = op_i.rd_cnt;
              state_d  = S_RDREQ;
            end
            default: ;
          endcase
        end
      end
      S_RDREQ: begin
        re      = 1'b1;
        state_d = S_RDWAIT;
      end
      S_RDWAIT: begin
        if (slot_free) begin
          out_d             = tpl_q;
          out_d.data_word   = rdata;
          out_d.last_result = (rem_q == 7'd1);
          ov_d              = 1'b1;
          rem_d             = rem_q - 7'd1;
          rd_idx_d          = rd_idx_q + AW'(1);
          state_d           = (rem_q == 7'd1) ? S_IDLE : S_RDREQ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  mbhr_ram #(
    .WIDTH (16),
    .DEPTH (REG_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      rem_q   <= rem_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    tpl_q    <= tpl_d;
    out_q    <= out_d;
  end

  assign busy_clear_o = (state_q == S_CLEAR);
  assign empty_o      = !ov_q;
  assign rsp_o        = out_q;

  // No result while the memory is being cleared
  a_no_out_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !ov_q)
    else $error("result pending during memory clear");

  // A burst never runs with nothing left to read
  a_burst_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDREQ || state_q == S_RDWAIT) |-> rem_q != 7'd0)
    else $error("read burst with zero remaining");

  // An unread result is held while not popped
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !pop_i) |=> (ov_q && $stable(out_q)))
    else $error("pending result changed without pop");

endmodule

FILE: src/modbus_holding_register_server_unit.sv
// Channel   | Direction | Handshake                 | Payload
// request   | in        | push / full               | req_i (pdu_byte, last_byte)
// response  | out       | empty / pop               | rsp_o (status .. last_result)
// config    | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (holding_start)
//
// One request byte is taken per cycle while the command queue has room.
// A read burst delivers each register word through a request and a wait state
// (registered memory read port) and stalls while a result is pending; echo and
// error results are registered directly. After reset, full stays high while the
// register memory is swept to zero; configuration writes are taken throughout.
// Front and back stall independently through a QUEUE_DEPTH entry queue.
module modbus_holding_register_server_unit #(
  parameter int unsigned REG_COUNT      = 64,
  parameter int unsigned MAX_READ_REGS  = 64,
  parameter int unsigned MAX_WRITE_REGS = 123
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  mbhr_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output mbhr_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);
  import mbhr_pkg::*;

  logic [15:0] hs_q;
  logic        accept, q_full, q_push, q_pop, q_valid, clearing;
  op_t         op_in, op_out;

  // Hold the configured window start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q <= 16'd1;
    end else if (cfg_valid_i) begin
      hs_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign full        = q_full || clearing;
  assign accept      = push && !full;

  mbhr_front #(
    .REG_COUNT      (REG_COUNT),
    .MAX_READ_REGS  (MAX_READ_REGS),
    .MAX_WRITE_REGS (MAX_WRITE_REGS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .req_i           (req_i),
    .holding_start_i (hs_q),
    .op_push_o       (q_push),
    .op_o            (op_in)
  );

  mbhr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (op_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (op_out)
  );

  mbhr_back #(
    .REG_COUNT (REG_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (q_valid),
    .op_i         (op_out),
    .op_pop_o     (q_pop),
    .busy_clear_o (clearing),
    .empty_o      (empty),
    .pop_i        (pop),
    .rsp_o        (rsp_o)
  );

endmodule

FILE: sim/mbhr_scoreboard.sv
`timescale 1ns / 1ps

// Watch the request, response and config channels; predict and compare
module mbhr_scoreboard #(
  parameter int unsigned REG_COUNT      = 64,
  parameter int unsigned MAX_READ_REGS  = 64,
  parameter int unsigned MAX_WRITE_REGS = 123
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  logic           full,
  input  mbhr_pkg::req_t req_i,
  input  logic           empty,
  input  logic           pop,
  input  mbhr_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i,
  output int             fail_count,
  output int             pending_count,
  output int             rsp_seen
);
  import mbhr_pkg::*;

  logic [15:0] regs_q [REG_COUNT];
  logic [7:0]  pos_q;
  logic [7:0]  hdr_q [6];
  logic [15:0] wptr_q;
  logic [1:0]  ferr_q;
  logic [7:0]  hi_q;
  logic [15:0] wbase_q;
  logic [15:0] hstart_q;
  rsp_t        expected_rsps [$];

  function automatic rsp_t err_rsp(status_e st, logic [7:0] fc);
    rsp_t r;
    r = '0;
    r.status = st;
    r.function_code = fc;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic logic win_ok(int unsigned a, int unsigned c);
    return a >= hstart_q && a + c <= int'(hstart_q) + REG_COUNT;
  endfunction

  // Advance the frame state by one request byte
  task automatic serve_byte(req_t rq);
    int unsigned p, cnt, adr, idx, len;
    logic [7:0] fc;
    rsp_t r;
    p = pos_q;
    if (p < 6) hdr_q[p] = rq.pdu_byte;
    fc = hdr_q[0];
    cnt = {hdr_q[3], hdr_q[4]};
    adr = ({hdr_q[1], hdr_q[2]} + 17'd1) & 16'hFFFF;
    if (fc == FC_WRITE_MULTI) begin
      if (p == 5) begin
        if (cnt < 1 || cnt > MAX_WRITE_REGS || hdr_q[5] != 2 * cnt)
          ferr_q = ST_VALUE;
        else if (!win_ok(adr, cnt))
          ferr_q = ST_ADDRESS;
        else begin
          wbase_q = 16'(adr - hstart_q);
          wptr_q = wbase_q;
        end
      end else if (p > 5 && ferr_q == 0) begin
        if (((p - 6) & 1) == 0) hi_q = rq.pdu_byte;
        else if (16'(wptr_q - wbase_q) < cnt && wptr_q < REG_COUNT) begin
          regs_q[wptr_q] = {hi_q, rq.pdu_byte};
          wptr_q++;
        end
      end
    end
    if (pos_q < 8'hFF) pos_q++;
    if (!rq.last_byte) return;
    len = p + 1;
    if (fc == FC_READ_HOLDING) begin
      if (len != 5 || cnt < 1 || cnt > MAX_READ_REGS)
        expected_rsps.push_back(err_rsp(ST_VALUE, fc));
      else if (!win_ok(adr, cnt))
        expected_rsps.push_back(err_rsp(ST_ADDRESS, fc));
      else begin
        for (int i = 0; i < cnt; i++) begin
          idx = adr - hstart_q + i;
          r = '0;
          r.function_code = fc;
          r.byte_count = 8'(2 * cnt);
          r.start_address = {hdr_q[1], hdr_q[2]};
          r.quantity = 16'(cnt);
          r.data_word = idx < REG_COUNT ? regs_q[idx] : 16'd0;
          r.last_result = (i + 1 == cnt);
          expected_rsps.push_back(r);
        end
      end
    end else if (fc == FC_WRITE_SINGLE) begin
      if (len != 5) expected_rsps.push_back(err_rsp(ST_VALUE, fc));
      else if (!win_ok(adr, 1)) expected_rsps.push_back(err_rsp(ST_ADDRESS, fc));
      else begin
        idx = adr - hstart_q;
        if (idx < REG_COUNT) regs_q[idx] = 16'(cnt);
        r = '0;
        r.function_code = fc;
        r.start_address = {hdr_q[1], hdr_q[2]};
        r.quantity = 16'(cnt);
        r.written_index = 16'(idx);
        r.written_count = 7'd1;
        r.last_result = 1'b1;
        expected_rsps.push_back(r);
      end
    end else if (fc == FC_WRITE_MULTI) begin
      if (len < 6) expected_rsps.push_back(err_rsp(ST_VALUE, fc));
      else if (ferr_q != 0) expected_rsps.push_back(err_rsp(status_e'(ferr_q), fc));
      else begin
        r = '0;
        r.function_code = fc;
        r.start_address = {hdr_q[1], hdr_q[2]};
        r.quantity = 16'(cnt);
        r.written_index = wbase_q;
        r.written_count = 7'(wptr_q - wbase_q);
        r.last_result = 1'b1;
        expected_rsps.push_back(r);
      end
    end else begin
      expected_rsps.push_back(err_rsp(ST_UNSUPPORTED, fc));
    end
    pos_q = 0;
    wptr_q = 0;
    ferr_q = 0;
    hi_q = 0;
    wbase_q = 0;
  endtask

  task automatic check_rsp(rsp_t got);
    rsp_t exp;
    if (expected_rsps.size() == 0) begin
      $error("unexpected response %h", got);
      fail_count++;
      return;
    end
    exp = expected_rsps.pop_front();
    if (got.status != exp.status) begin
      $error("status exp %0d got %0d", exp.status, got.status); fail_count++;
    end
    if (got.function_code != exp.function_code) begin
      $error("function_code exp %0d got %0d", exp.function_code, got.function_code);
      fail_count++;
    end
    if (got.byte_count != exp.byte_count) begin
      $error("byte_count exp %0d got %0d", exp.byte_count, got.byte_count); fail_count++;
    end
    if (got.start_address != exp.start_address) begin
      $error("start_address exp %h got %h", exp.start_address, got.start_address);
      fail_count++;
    end
    if (got.quantity != exp.quantity) begin
      $error("quantity exp %h got %h", exp.quantity, got.quantity); fail_count++;
    end
    if (got.data_word != exp.data_word) begin
      $error("data_word exp %h got %h", exp.data_word, got.data_word); fail_count++;
    end
    if (got.written_index != exp.written_index) begin
      $error("written_index exp %h got %h", exp.written_index, got.written_index);
      fail_count++;
    end
    if (got.written_count != exp.written_count) begin
      $error("written_count exp %0d got %0d", exp.written_count, got.written_count);
      fail_count++;
    end
    if (got.last_result != exp.last_result) begin
      $error("last_result exp %0d got %0d", exp.last_result, got.last_result);
      fail_count++;
    end
  endtask

  // Sample every accepted transaction at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (regs_q[i]) regs_q[i] = '0;
      foreach (hdr_q[i]) hdr_q[i] = '0;
      pos_q = 0; wptr_q = 0; ferr_q = 0; hi_q = 0; wbase_q = 0;
      hstart_q = 16'd1;
      expected_rsps.delete();
      fail_count = 0;
      rsp_seen = 0;
      pending_count = 0;
    end else begin
      if (pop && !empty) begin
        check_rsp(rsp_o);
        rsp_seen++;
      end
      if (push && !full) serve_byte(req_i);
      if (cfg_valid_i && cfg_ready_o) hstart_q = cfg_data_i;
      pending_count = expected_rsps.size();
    end
  end

endmodule

FILE: sim/tb_modbus_holding_register_server_unit.sv
`timescale 1ns / 1ps

module tb_modbus_holding_register_server_unit;
  import mbhr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  req_t        req_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  rsp_t        rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  int          fail_count, pending_count, rsp_seen;
  int          push_idle_pct, pop_idle_pct;
  int          idle_cycles = 0;
  int          bytes_sent;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  modbus_holding_register_server_unit dut (
    .clk_i, .rst_ni, .push, .full, .req_i, .empty, .pop, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  mbhr_scoreboard checker_u (
    .clk_i, .rst_ni, .push, .full, .req_i, .empty, .pop, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count, .pending_count, .rsp_seen
  );

  // Random stalls on the response side
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  // Count cycles with no accepted transaction
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Hold push across back-to-back bytes, drop it only while idling
  task automatic send_byte(logic [7:0] b, logic lst);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    req_i <= '{pdu_byte: b, last_byte: lst};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(logic [7:0] f [$]);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic send_hdr(logic [7:0] fc, logic [15:0] adr, logic [15:0] w,
                          int n_extra);
    logic [7:0] f [$];
    f = '{fc, adr[15:8], adr[7:0], w[15:8], w[7:0]};
    repeat (n_extra) f.push_back(8'($urandom));
    send_frame(f);
  endtask

  task automatic send_multi(logic [15:0] adr, int cnt, int bc, int data_bytes);
    logic [7:0] f [$];
    f = '{FC_WRITE_MULTI, adr[15:8], adr[7:0], 8'(cnt >> 8), 8'(cnt), 8'(bc)};
    repeat (data_bytes) f.push_back(8'($urandom));
    send_frame(f);
  endtask

  // Drain expected responses, then let the block settle
  task automatic quiesce();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_start(logic [15:0] v);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly legal requests inside the window, with some noise
  task automatic random_request(logic [15:0] hs);
    int kind, cnt;
    logic [15:0] adr;
    kind = $urandom_range(99);
    cnt = $urandom_range(1, 4);
    adr = 16'(hs - 1 + $urandom_range(0, 64 - cnt));
    if ($urandom_range(9) == 0) adr = 16'($urandom);
    if (kind < 30) send_hdr(FC_READ_HOLDING, adr, 16'(cnt), 0);
    else if (kind < 50) send_hdr(FC_WRITE_SINGLE, adr, 16'($urandom), 0);
    else if (kind < 80) send_multi(adr, cnt, 2 * cnt, 2 * cnt);
    else if (kind < 85) send_multi(adr, cnt, 2 * cnt, $urandom_range(0, 2 * cnt + 3));
    else if (kind < 90) send_multi(adr, $urandom_range(0, 130), $urandom_range(255), 2);
    else if (kind < 95) send_hdr(FC_READ_HOLDING, adr, 16'($urandom_range(0, 70)),
                                 $urandom_range(0, 1));
    else send_hdr(8'($urandom), 16'($urandom), 16'($urandom), $urandom_range(0, 2));
  endtask

  initial begin
    logic [15:0] hs;
    logic [7:0] f [$];
    push_idle_pct = 8;
    pop_idle_pct = 67;
    bytes_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every function, error paths
    send_hdr(FC_READ_HOLDING, 16'h0000, 16'd64, 0);
    send_hdr(FC_WRITE_SINGLE, 16'h0000, 16'hFFFF, 0);
    send_hdr(FC_WRITE_SINGLE, 16'h003F, 16'hA5A5, 0);
    send_hdr(FC_WRITE_SINGLE, 16'h0040, 16'h1234, 0);
    send_hdr(FC_WRITE_SINGLE, 16'hFFFF, 16'h1234, 0);
    send_hdr(FC_READ_HOLDING, 16'h0000, 16'd0, 0);
    send_hdr(FC_READ_HOLDING, 16'h0000, 16'd65, 0);
    send_hdr(FC_READ_HOLDING, 16'hFFFF, 16'hFFFF, 0);
    send_hdr(FC_READ_HOLDING, 16'h0001, 16'd64, 0);
    send_hdr(FC_READ_HOLDING, 16'h0000, 16'd2, 1);
    send_hdr(FC_WRITE_SINGLE, 16'h0000, 16'd2, 2);
    send_multi(16'h0000, 4, 8, 8);
    send_multi(16'h0000, 4, 8, 3);
    send_multi(16'h0000, 2, 4, 9);
    send_multi(16'h0000, 0, 0, 2);
    send_multi(16'h0000, 123, 246, 4);
    send_multi(16'h0000, 124, 248, 2);
    send_multi(16'h003E, 4, 8, 8);
    send_multi(16'hFFFF, 1, 2, 2);
    f = '{FC_WRITE_MULTI, 8'h00, 8'h00, 8'h00};
    send_frame(f);
    send_hdr(8'hFF, 16'hFFFF, 16'hFFFF, 0);
    send_hdr(8'h00, 16'h0000, 16'h0000, 0);
    // Frame longer than the byte position range
    f = '{FC_READ_HOLDING};
    repeat (256) f.push_back(8'($urandom));
    send_frame(f);
    send_hdr(FC_READ_HOLDING, 16'h0000, 16'd64, 0);

    // Random phases across start addresses, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: hs = 16'h0000;
        1: hs = 16'hFFFF;
        2: hs = 16'hFFC0;
        3: hs = 16'($urandom);
        4: hs = 16'h0001;
        default: hs = 16'($urandom_range(1, 100));
      endcase
      if (ph == 2) begin push_idle_pct = 67; pop_idle_pct = 8; end
      if (ph == 4) begin push_idle_pct = 0; pop_idle_pct = 0; end
      write_start(hs);
      repeat (2) random_request(hs);
    end

    quiesce();
    $display("Sent %0d request bytes, checked %0d responses", bytes_sent, rsp_seen);
    $display("Covered reads, single and multiple writes, errors and six window starts");
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
